// ===== hw/rtl/rgbhsl_pkg.sv =====
package rgbhsl_pkg;

  // Extra bits on the hue remainder and divisor, which hold up to six times
  // the channel difference.
  localparam int HUE_GUARD = 3;

  // Control that travels with every beat through the pipeline.
  typedef struct packed {
    logic valid;
    logic grey;
  } ctl_t;

endpackage

// ===== hw/rtl/rgbhsl_front.sv =====
module rgbhsl_front #(
  parameter int CHANNEL_BITS  = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         en,
  input  logic                                         in_valid,
  input  logic [CHANNEL_BITS-1:0]                      red,
  input  logic [CHANNEL_BITS-1:0]                      green,
  input  logic [CHANNEL_BITS-1:0]                      blue,
  output rgbhsl_pkg::ctl_t                             ctl,
  output logic [CHANNEL_BITS+rgbhsl_pkg::HUE_GUARD-1:0] h_rem,
  output logic [CHANNEL_BITS+rgbhsl_pkg::HUE_GUARD-1:0] h_dvs,
  output logic [CHANNEL_BITS-1:0]                      s_rem,
  output logic [CHANNEL_BITS-1:0]                      s_dvs,
  output logic [FRACTION_BITS-1:0]                     s_low,
  output logic [CHANNEL_BITS:0]                        light
);
  import rgbhsl_pkg::*;

  localparam int CB = CHANNEL_BITS;
  localparam int FB = FRACTION_BITS;
  localparam int HW = CB + HUE_GUARD;
  localparam logic [CB:0] CMAX  = {1'b0, {CB{1'b1}}};
  localparam logic [CB:0] CMAX2 = {{CB{1'b1}}, 1'b0};

  logic [CB-1:0]    mx;
  logic [CB-1:0]    mn;
  logic [CB-1:0]    d;
  logic [CB:0]      sum;
  logic [CB:0]      q_wide;
  logic [HW-1:0]    dx;
  logic [HW-1:0]    rx;
  logic [HW-1:0]    gx;
  logic [HW-1:0]    bx;
  logic [HW-1:0]    n;
  logic [CB+FB-1:0] m;

  // Largest and smallest channel, their difference and their sum.
  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    d   = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
  end

  // Hue numerator: sector offset times the difference plus the sector term.
  always_comb begin
    dx = {{HUE_GUARD{1'b0}}, d};
    rx = {{HUE_GUARD{1'b0}}, red};
    gx = {{HUE_GUARD{1'b0}}, green};
    bx = {{HUE_GUARD{1'b0}}, blue};
    if (red == mx) begin
      if (green >= blue) begin
        n = gx - bx;
      end else begin
        n = (dx << 2) + (dx << 1) - (bx - gx);
      end
    end else if (green == mx) begin
      n = (dx << 1) + bx - rx;
    end else begin
      n = (dx << 2) + rx - gx;
    end
  end

  // Saturation divisor and the dividend d * (2^FB - 1).
  always_comb begin
    if (sum <= CMAX) begin
      q_wide = sum;
    end else begin
      q_wide = CMAX2 - sum;
    end
    m = {d, {FB{1'b0}}} - {{FB{1'b0}}, d};
  end

  // Register the first stage of the division chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl.valid <= in_valid;
      ctl.grey  <= (d == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_rem <= n;
      h_dvs <= (dx << 2) + (dx << 1);
      s_rem <= m[CB+FB-1:FB];
      s_dvs <= q_wide[CB-1:0];
      s_low <= m[FB-1:0];
      light <= sum;
    end
  end

endmodule

// ===== hw/rtl/rgbhsl_cell.sv =====
module rgbhsl_cell #(
  parameter int CHANNEL_BITS  = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         en,
  input  rgbhsl_pkg::ctl_t                             ctl_in,
  input  logic [CHANNEL_BITS+rgbhsl_pkg::HUE_GUARD-1:0] h_rem_in,
  input  logic [CHANNEL_BITS+rgbhsl_pkg::HUE_GUARD-1:0] h_dvs_in,
  input  logic [FRACTION_BITS-1:0]                     h_quo_in,
  input  logic [CHANNEL_BITS-1:0]                      s_rem_in,
  input  logic [CHANNEL_BITS-1:0]                      s_dvs_in,
  input  logic [FRACTION_BITS-1:0]                     s_low_in,
  input  logic [FRACTION_BITS-1:0]                     s_quo_in,
  input  logic [CHANNEL_BITS:0]                        light_in,
  output rgbhsl_pkg::ctl_t                             ctl_out,
  output logic [CHANNEL_BITS+rgbhsl_pkg::HUE_GUARD-1:0] h_rem_out,
  output logic [CHANNEL_BITS+rgbhsl_pkg::HUE_GUARD-1:0] h_dvs_out,
  output logic [FRACTION_BITS-1:0]                     h_quo_out,
  output logic [CHANNEL_BITS-1:0]                      s_rem_out,
  output logic [CHANNEL_BITS-1:0]                      s_dvs_out,
  output logic [FRACTION_BITS-1:0]                     s_low_out,
  output logic [FRACTION_BITS-1:0]                     s_quo_out,
  output logic [CHANNEL_BITS:0]                        light_out
);
  import rgbhsl_pkg::*;

  localparam int CB = CHANNEL_BITS;
  localparam int FB = FRACTION_BITS;
  localparam int HW = CB + HUE_GUARD;

  logic [HW:0]   h_try;
  logic [HW:0]   h_diff;
  logic          h_bit;
  logic [HW-1:0] h_rem_next;
  logic [CB:0]   s_try;
  logic [CB:0]   s_diff;
  logic          s_bit;
  logic [CB-1:0] s_rem_next;

  // One restoring step for hue: double the remainder, subtract if it fits.
  always_comb begin
    h_try      = {h_rem_in, 1'b0};
    h_diff     = h_try - {1'b0, h_dvs_in};
    h_bit      = (h_try >= {1'b0, h_dvs_in});
    h_rem_next = h_bit ? h_diff[HW-1:0] : h_try[HW-1:0];
  end

  // One restoring step for saturation, shifting in the next dividend bit.
  always_comb begin
    s_try      = {s_rem_in, s_low_in[FB-1]};
    s_diff     = s_try - {1'b0, s_dvs_in};
    s_bit      = (s_try >= {1'b0, s_dvs_in});
    s_rem_next = s_bit ? s_diff[CB-1:0] : s_try[CB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_rem_out <= h_rem_next;
      h_dvs_out <= h_dvs_in;
      h_quo_out <= {h_quo_in[FB-2:0], h_bit};
      s_rem_out <= s_rem_next;
      s_dvs_out <= s_dvs_in;
      s_low_out <= {s_low_in[FB-2:0], 1'b0};
      s_quo_out <= {s_quo_in[FB-2:0], s_bit};
      light_out <= light_in;
    end
  end

endmodule

// ===== hw/rtl/rgbhsl_round.sv =====
module rgbhsl_round #(
  parameter int CHANNEL_BITS  = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         en,
  input  rgbhsl_pkg::ctl_t                             ctl,
  input  logic [CHANNEL_BITS+rgbhsl_pkg::HUE_GUARD-1:0] h_rem,
  input  logic [CHANNEL_BITS+rgbhsl_pkg::HUE_GUARD-1:0] h_dvs,
  input  logic [FRACTION_BITS-1:0]                     h_quo,
  input  logic [CHANNEL_BITS-1:0]                      s_rem,
  input  logic [CHANNEL_BITS-1:0]                      s_dvs,
  input  logic [FRACTION_BITS-1:0]                     s_quo,
  input  logic [CHANNEL_BITS:0]                        light,
  output logic                                         out_valid,
  output logic [FRACTION_BITS-1:0]                     hue,
  output logic [FRACTION_BITS-1:0]                     saturation,
  output logic [CHANNEL_BITS:0]                        lightness_twice
);
  import rgbhsl_pkg::*;

  localparam int FB = FRACTION_BITS;

  logic          h_up;
  logic          s_up;
  logic [FB-1:0] hue_next;
  logic [FB-1:0] saturation_next;

  // Round to nearest: bump the quotient when twice the remainder reaches
  // the divisor. Hue wraps around a full turn.
  always_comb begin
    h_up = ({h_rem, 1'b0} >= {1'b0, h_dvs});
    s_up = ({s_rem, 1'b0} >= {1'b0, s_dvs});
    if (ctl.grey) begin
      hue_next        = '0;
      saturation_next = '0;
    end else begin
      hue_next        = h_quo + {{(FB-1){1'b0}}, h_up};
      saturation_next = s_quo + {{(FB-1){1'b0}}, s_up};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue             <= hue_next;
      saturation      <= saturation_next;
      lightness_twice <= light;
    end
  end

endmodule

// ===== hw/rtl/rgb_to_hsl_unit.sv =====
// RGB to HSL converter, fully pipelined: one pixel beat accepted per clock while the chain advances.
// The pipeline has one input stage, one
// restoring division cell per fraction bit for hue and saturation side by
// side, and one rounding and output register stage.
// The whole chain advances together while the output register is empty or
// being taken. Synchronous active-high reset clears all valid flags.
module rgb_to_hsl_unit #(
  parameter int CHANNEL_BITS  = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CHANNEL_BITS-1:0]  red,
  input  logic [CHANNEL_BITS-1:0]  green,
  input  logic [CHANNEL_BITS-1:0]  blue,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [FRACTION_BITS-1:0] hue,
  output logic [FRACTION_BITS-1:0] saturation,
  output logic [CHANNEL_BITS:0]    lightness_twice
);
  import rgbhsl_pkg::*;

  localparam int CB = CHANNEL_BITS;
  localparam int FB = FRACTION_BITS;
  localparam int HW = CB + HUE_GUARD;

  logic          en;
  ctl_t          ctl   [0:FB];
  logic [HW-1:0] h_rem [0:FB];
  logic [HW-1:0] h_dvs [0:FB];
  logic [FB-1:0] h_quo [0:FB];
  logic [CB-1:0] s_rem [0:FB];
  logic [CB-1:0] s_dvs [0:FB];
  logic [FB-1:0] s_low [0:FB];
  logic [FB-1:0] s_quo [0:FB];
  logic [CB:0]   light [0:FB];

  // The chain moves whenever the output register can take a new beat.
  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  // Quotients start empty at the head of the chain.
  assign h_quo[0] = '0;
  assign s_quo[0] = '0;

  rgbhsl_front #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_valid(in_valid),
    .red     (red),
    .green   (green),
    .blue    (blue),
    .ctl     (ctl[0]),
    .h_rem   (h_rem[0]),
    .h_dvs   (h_dvs[0]),
    .s_rem   (s_rem[0]),
    .s_dvs   (s_dvs[0]),
    .s_low   (s_low[0]),
    .light   (light[0])
  );

  // One cell per quotient bit.
  for (genvar i = 0; i < FB; i++) begin : g_cell
    rgbhsl_cell #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .FRACTION_BITS(FRACTION_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (ctl[i]),
      .h_rem_in (h_rem[i]),
      .h_dvs_in (h_dvs[i]),
      .h_quo_in (h_quo[i]),
      .s_rem_in (s_rem[i]),
      .s_dvs_in (s_dvs[i]),
      .s_low_in (s_low[i]),
      .s_quo_in (s_quo[i]),
      .light_in (light[i]),
      .ctl_out  (ctl[i+1]),
      .h_rem_out(h_rem[i+1]),
      .h_dvs_out(h_dvs[i+1]),
      .h_quo_out(h_quo[i+1]),
      .s_rem_out(s_rem[i+1]),
      .s_dvs_out(s_dvs[i+1]),
      .s_low_out(s_low[i+1]),
      .s_quo_out(s_quo[i+1]),
      .light_out(light[i+1])
    );
  end

  rgbhsl_round #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_round (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .ctl            (ctl[FB]),
    .h_rem          (h_rem[FB]),
    .h_dvs          (h_dvs[FB]),
    .h_quo          (h_quo[FB]),
    .s_rem          (s_rem[FB]),
    .s_dvs          (s_dvs[FB]),
    .s_quo          (s_quo[FB]),
    .light          (light[FB]),
    .out_valid      (out_valid),
    .hue            (hue),
    .saturation     (saturation),
    .lightness_twice(lightness_twice)
  );

  // The leftover dividend bits of the last cell are not needed.
  logic unused_low;
  assign unused_low = ^s_low[FB];

endmodule

// ===== hw/rtl/rgbhsl_checker.sv =====
module rgbhsl_checker #(
  parameter int CHANNEL_BITS  = 8,
  parameter int FRACTION_BITS = 16
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [FRACTION_BITS-1:0] hue,
  input logic [FRACTION_BITS-1:0] saturation,
  input logic [CHANNEL_BITS:0]    lightness_twice
);
  import rgbhsl_pkg::*;

  localparam logic [CHANNEL_BITS:0] LIGHT_MAX = {{CHANNEL_BITS{1'b1}}, 1'b0};

  // A result beat that is held back keeps its values.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hue) && $stable(saturation)
      && $stable(lightness_twice))
    else $error("output beat changed while stalled");

  // The input side never stalls while the output side takes beats.
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output was ready");

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // Twice the lightness never exceeds twice the full channel value.
  a_light_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> lightness_twice <= LIGHT_MAX)
    else $error("lightness out of range");

  // A black pixel is grey: no hue and no saturation.
  a_black_grey: assert property (@(posedge clk) disable iff (rst)
    out_valid && lightness_twice == '0 |-> hue == '0 && saturation == '0)
    else $error("black pixel with hue or saturation");

  // Keep the input valid in view for waveform debug.
  logic unused_in_valid;
  assign unused_in_valid = in_valid;

endmodule

bind rgb_to_hsl_unit rgbhsl_checker #(
  .CHANNEL_BITS (CHANNEL_BITS),
  .FRACTION_BITS(FRACTION_BITS)
) u_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .hue            (hue),
  .saturation     (saturation),
  .lightness_twice(lightness_twice)
);

// ===== dv/hsl_result_checker.sv =====
`timescale 1ns / 100ps

module hsl_result_checker #(
  parameter int CHANNEL_BITS  = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [CHANNEL_BITS-1:0]  red,
  input  logic [CHANNEL_BITS-1:0]  green,
  input  logic [CHANNEL_BITS-1:0]  blue,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [FRACTION_BITS-1:0] hue,
  input  logic [FRACTION_BITS-1:0] saturation,
  input  logic [CHANNEL_BITS:0]    lightness_twice,
  output int                       errors,
  output int                       pending
);

  localparam longint CHAN_MAX = (longint'(1) << CHANNEL_BITS) - 1;
  localparam longint HUE_ONE  = longint'(1) << FRACTION_BITS;
  localparam longint SAT_MAX  = HUE_ONE - 1;

  typedef struct {
    logic [FRACTION_BITS-1:0] hue;
    logic [FRACTION_BITS-1:0] saturation;
    logic [CHANNEL_BITS:0]    lightness_twice;
  } hsl_t;

  // Converted pixels waiting for their output beat, oldest first.
  hsl_t hsl_expected_q[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Exact six-sector hue and HSL saturation, each rounded once, halves up.
  function automatic hsl_t convert_rgb_to_hsl(input logic [CHANNEL_BITS-1:0] r_in,
                                              input logic [CHANNEL_BITS-1:0] g_in,
                                              input logic [CHANNEL_BITS-1:0] b_in);
    longint r, g, b, mx, mn, d, sum, n, q;
    hsl_t   res;
    r = r_in;
    g = g_in;
    b = b_in;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d   = mx - mn;
    sum = mx + mn;
    res.hue             = '0;
    res.saturation      = '0;
    res.lightness_twice = sum[CHANNEL_BITS:0];
    // A grey pixel keeps hue and saturation at zero.
    if (d > 0) begin
      if (r == mx) begin
        n = ((g >= b) ? 0 : 6 * d) + (g - b);
      end else if (g == mx) begin
        n = 2 * d + (b - r);
      end else begin
        n = 4 * d + (r - g);
      end
      res.hue = FRACTION_BITS'((2 * n * HUE_ONE + 6 * d) / (12 * d));
      q = (sum <= CHAN_MAX) ? sum : 2 * CHAN_MAX - sum;
      res.saturation = FRACTION_BITS'((2 * d * SAT_MAX + q) / (2 * q));
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR at %0t ns: %s got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Predict on every accepted input beat and check every accepted output beat.
  always @(posedge clk) begin
    hsl_t want;
    if (rst) begin
      hsl_expected_q.delete();
      pending <= 0;
    end else begin
      if (in_valid && in_ready) begin
        hsl_expected_q.push_back(convert_rgb_to_hsl(red, green, blue));
      end
      if (out_valid && out_ready) begin
        if (hsl_expected_q.size() == 0) begin
          report_mismatch("output beat with nothing expected, hue", hue, -1);
        end else begin
          want = hsl_expected_q.pop_front();
          if (hue !== want.hue) report_mismatch("hue", hue, want.hue);
          if (saturation !== want.saturation) begin
            report_mismatch("saturation", saturation, want.saturation);
          end
          if (lightness_twice !== want.lightness_twice) begin
            report_mismatch("lightness_twice", lightness_twice, want.lightness_twice);
          end
        end
      end
      pending <= hsl_expected_q.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int CHANNEL_BITS  = 8;
  localparam int FRACTION_BITS = 16;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_BLOCKS = 12;
  localparam int BLOCK_PIXELS  = 100;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CHANNEL_BITS-1:0]  red = '0;
  logic [CHANNEL_BITS-1:0]  green = '0;
  logic [CHANNEL_BITS-1:0]  blue = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [FRACTION_BITS-1:0] hue;
  logic [FRACTION_BITS-1:0] saturation;
  logic [CHANNEL_BITS:0]    lightness_twice;

  // When set, neither side inserts idle cycles.
  logic calm = 1'b0;
  int   stall_left = 0;
  int   idle_cycles = 0;
  int   errors;
  int   pending;

  rgb_to_hsl_unit #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hue            (hue),
    .saturation     (saturation),
    .lightness_twice(lightness_twice)
  );

  hsl_result_checker #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hue            (hue),
    .saturation     (saturation),
    .lightness_twice(lightness_twice),
    .errors         (errors),
    .pending        (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: after each taken beat, drop ready for a random number of cycles.
  always @(posedge clk) begin
    int wait_cycles;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (!out_ready) begin
      if (stall_left == 0) out_ready <= 1'b1;
      else stall_left <= stall_left - 1;
    end else if (out_valid) begin
      wait_cycles = calm ? 0 : $urandom_range(0, 13);
      if (wait_cycles > 0) begin
        out_ready  <= 1'b0;
        stall_left <= wait_cycles - 1;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drive one pixel beat after a random gap and hold it until it is taken.
  task automatic send_pixel(input int r, input int g, input int b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    red      <= CHANNEL_BITS'(r);
    green    <= CHANNEL_BITS'(g);
    blue     <= CHANNEL_BITS'(b);
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending until every converted pixel has come out.
  task automatic drain_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Put three channel values into one of the six channel orders.
  task automatic send_permuted(input int a, input int b, input int c);
    case ($urandom_range(0, 5))
      0: send_pixel(a, b, c);
      1: send_pixel(a, c, b);
      2: send_pixel(b, a, c);
      3: send_pixel(b, c, a);
      4: send_pixel(c, a, b);
      default: send_pixel(c, b, a);
    endcase
  endtask

  // One random pixel, biased toward greys, ties and the saturation boundary.
  task automatic send_random_pixel();
    int hi, lo, s;
    case ($urandom_range(0, 9))
      4: begin
        hi = $urandom_range(0, 255);
        send_pixel(hi, hi, hi);
      end
      5: begin
        hi = $urandom_range(1, 255);
        send_permuted(hi, hi, $urandom_range(0, hi - 1));
      end
      6: begin
        send_pixel(int'({1'($urandom_range(0, 1)),
                         7'($urandom_range(0, 1) ? 7'h7f : 7'h00)}),
                   ($urandom_range(0, 1) ? 255 : $urandom_range(0, 1)),
                   ($urandom_range(0, 1) ? 0 : $urandom_range(254, 255)));
      end
      7: begin
        // Channel sums at and around the point where the saturation divisor turns.
        s  = $urandom_range(254, 256);
        hi = $urandom_range(128, 255);
        lo = s - hi;
        if (lo < 0) lo = 0;
        send_permuted(hi, lo, $urandom_range(lo, hi));
      end
      8: begin
        hi = $urandom_range(0, 250);
        send_permuted(hi, hi + $urandom_range(0, 5), hi + $urandom_range(0, 5));
      end
      default: send_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255));
    endcase
  endtask

  // Stimulus: directed corners, then random blocks with changing idle behavior.
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_pixel(0, 0, 0);
    send_pixel(255, 255, 255);
    send_pixel(128, 128, 128);
    send_pixel(255, 0, 0);
    send_pixel(0, 255, 0);
    send_pixel(0, 0, 255);
    send_pixel(255, 255, 0);
    send_pixel(0, 255, 255);
    send_pixel(255, 0, 255);
    send_pixel(255, 0, 1);
    send_pixel(1, 0, 0);
    send_pixel(0, 0, 1);
    send_pixel(128, 127, 127);
    send_pixel(128, 128, 127);
    send_pixel(129, 128, 128);
    send_pixel(254, 1, 1);
    send_pixel(200, 200, 50);
    send_pixel(50, 200, 200);
    send_pixel(200, 50, 200);
    send_pixel(1, 1, 0);
    send_pixel(254, 255, 255);
    send_pixel(170, 85, 255);
    drain_outputs();

    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      calm <= ($urandom_range(0, 3) == 0);
      for (int i = 0; i < BLOCK_PIXELS; i++) send_random_pixel();
      if (blk == RANDOM_BLOCKS / 2) drain_outputs();
    end

    drain_outputs();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
